// ===== sv/mbtrc_pkg.sv =====
// Shared types and constants for the Modbus TCP request checker.
`timescale 1ns / 1ps
`default_nettype none

package mbtrc_pkg;

  // Frame capture
  localparam int unsigned HDR_DEPTH = 13;
  localparam int unsigned HDR_IDX_W = 4;
  localparam int unsigned CNT_W     = 17;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Size rules
  localparam logic [CNT_W-1:0] MIN_SIZE   = 17'd8;
  localparam logic [CNT_W-1:0] MBAP_FIXED = 17'd6;
  localparam logic [CNT_W-1:0] READ_MIN   = 17'd12;
  localparam logic [CNT_W-1:0] WMULTI_MIN = 17'd13;
  localparam logic [15:0]      PDU_LEN_FIXED = 16'd6;

  // Supported function codes
  localparam logic [7:0] FC_READ_HOLDING = 8'd3;
  localparam logic [7:0] FC_READ_INPUT   = 8'd4;
  localparam logic [7:0] FC_WRITE_SINGLE = 8'd6;
  localparam logic [7:0] FC_WRITE_MULTI  = 8'd16;

  // Queue between front and back
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = 1;
  localparam int unsigned Q_CNT_W = 2;

  typedef enum logic [3:0] {
    ERR_NONE     = 4'd0,
    ERR_SHORT    = 4'd1,
    ERR_PROTOCOL = 4'd2,
    ERR_LENGTH   = 4'd3,
    ERR_NO_FUNC  = 4'd4,
    ERR_UNSUP    = 4'd5,
    ERR_PAYLOAD  = 4'd6,
    ERR_QUANTITY = 4'd7,
    ERR_BYTE_CNT = 4'd8
  } err_t;

  // One completed request as handed from front to back
  typedef struct packed {
    logic [HDR_DEPTH-1:0][7:0] hdr;
    logic [CNT_W-1:0]          total;
  } frame_t;

endpackage

`default_nettype wire

// ===== sv/mbtrc_front.sv =====
// Front end: counts request bytes and captures the header.
`timescale 1ns / 1ps
`default_nettype none

module mbtrc_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [7:0]         in_data_byte,
  input  wire logic               in_last_byte,
  input  wire logic               q_full,
  output logic                    q_push,
  output mbtrc_pkg::frame_t       q_frame
);

  logic [mbtrc_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [mbtrc_pkg::CNT_W-1:0] total;
  logic [mbtrc_pkg::HDR_DEPTH-1:0][7:0] hdr_r, hdr_nxt;
  logic accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  // Saturating size including the current byte
  assign total = (cnt_r == mbtrc_pkg::CNT_MAX) ? mbtrc_pkg::CNT_MAX
                                                : cnt_r + 1'b1;

  // Header capture: byte lands at its own slot while the count is below depth
  always_comb begin
    for (int i = 0; i < mbtrc_pkg::HDR_DEPTH; i++) begin
      if (accept && (cnt_r == mbtrc_pkg::CNT_W'(i)))
        hdr_nxt[i] = in_data_byte;
      else
        hdr_nxt[i] = hdr_r[i];
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (accept)
      cnt_nxt = in_last_byte ? '0 : total;
  end

  // Completed request goes to the queue with the last byte folded in
  assign q_push  = accept && in_last_byte;
  assign q_frame = {hdr_nxt, total};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hdr_r <= hdr_nxt;
  end

endmodule

`default_nettype wire

// ===== sv/mbtrc_queue.sv =====
// Short queue of completed requests between front and back.
`timescale 1ns / 1ps
`default_nettype none

module mbtrc_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire mbtrc_pkg::frame_t push_frame,
  output logic                   full,
  input  wire logic              pop,
  output logic                   head_valid,
  output mbtrc_pkg::frame_t      head_frame
);

  mbtrc_pkg::frame_t entry_r [mbtrc_pkg::Q_DEPTH];
  logic [mbtrc_pkg::Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [mbtrc_pkg::Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [mbtrc_pkg::Q_CNT_W-1:0] count_r, count_nxt;
  logic do_push, do_pop;

  assign full       = (count_r == mbtrc_pkg::Q_CNT_W'(mbtrc_pkg::Q_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_frame = entry_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == mbtrc_pkg::Q_PTR_W'(mbtrc_pkg::Q_DEPTH - 1)) ? '0
                                                                            : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == mbtrc_pkg::Q_PTR_W'(mbtrc_pkg::Q_DEPTH - 1)) ? '0
                                                                            : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push)
      entry_r[wr_ptr_r] <= push_frame;
  end

endmodule

`default_nettype wire

// ===== sv/mbtrc_back.sv =====
// Back end: checks a captured request and holds the result register.
`timescale 1ns / 1ps
`default_nettype none

module mbtrc_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              head_valid,
  input  wire mbtrc_pkg::frame_t head_frame,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   out_ok,
  output logic [3:0]             out_error_code,
  output logic [15:0]            out_txn_id,
  output logic [15:0]            out_proto,
  output logic [15:0]            out_length_field,
  output logic [7:0]             out_unit_id,
  output logic [7:0]             out_func,
  output logic [15:0]            out_start_address,
  output logic [15:0]            out_quantity,
  output logic [15:0]            out_write_value
);

  logic [15:0] trans_id, proto_id, len_field, start_addr, word10;
  logic [7:0]  unit, fc, bc;
  logic [mbtrc_pkg::CNT_W-1:0] total;
  mbtrc_pkg::err_t err;
  logic ok;

  logic        valid_r, valid_nxt;
  logic        ok_r;
  logic [3:0]  err_r;
  logic [15:0] trans_r, proto_r, len_r, addr_r, qty_r, wval_r;
  logic [7:0]  unit_r, fc_r;

  // Header fields, big endian
  assign trans_id   = {head_frame.hdr[0],  head_frame.hdr[1]};
  assign proto_id   = {head_frame.hdr[2],  head_frame.hdr[3]};
  assign len_field  = {head_frame.hdr[4],  head_frame.hdr[5]};
  assign unit       = head_frame.hdr[6];
  assign fc         = head_frame.hdr[7];
  assign start_addr = {head_frame.hdr[8],  head_frame.hdr[9]};
  assign word10     = {head_frame.hdr[10], head_frame.hdr[11]};
  assign bc         = head_frame.hdr[12];
  assign total      = head_frame.total;

  // Ordered checks: size, protocol, length, then per-function rules
  always_comb begin
    err = mbtrc_pkg::ERR_NONE;
    if (total < mbtrc_pkg::MIN_SIZE) begin
      err = mbtrc_pkg::ERR_SHORT;
    end else if (proto_id != '0) begin
      err = mbtrc_pkg::ERR_PROTOCOL;
    end else if ((mbtrc_pkg::CNT_W'(len_field) + mbtrc_pkg::MBAP_FIXED) != total) begin
      err = mbtrc_pkg::ERR_LENGTH;
    end else begin
      unique case (fc) inside
        mbtrc_pkg::FC_READ_HOLDING, mbtrc_pkg::FC_READ_INPUT: begin
          if (total < mbtrc_pkg::READ_MIN)
            err = mbtrc_pkg::ERR_PAYLOAD;
          else if (word10 == '0)
            err = mbtrc_pkg::ERR_QUANTITY;
          else if (len_field != mbtrc_pkg::PDU_LEN_FIXED)
            err = mbtrc_pkg::ERR_PAYLOAD;
        end
        mbtrc_pkg::FC_WRITE_SINGLE: begin
          if (total < mbtrc_pkg::READ_MIN)
            err = mbtrc_pkg::ERR_PAYLOAD;
          else if (len_field != mbtrc_pkg::PDU_LEN_FIXED)
            err = mbtrc_pkg::ERR_PAYLOAD;
        end
        mbtrc_pkg::FC_WRITE_MULTI: begin
          if (total < mbtrc_pkg::WMULTI_MIN)
            err = mbtrc_pkg::ERR_PAYLOAD;
          else if (word10 == '0)
            err = mbtrc_pkg::ERR_QUANTITY;
          else if (mbtrc_pkg::CNT_W'(bc) != {word10, 1'b0})
            err = mbtrc_pkg::ERR_BYTE_CNT;
          else if (total != (mbtrc_pkg::WMULTI_MIN + mbtrc_pkg::CNT_W'(bc)))
            err = mbtrc_pkg::ERR_PAYLOAD;
        end
        default: err = mbtrc_pkg::ERR_UNSUP;
      endcase
    end
  end

  assign ok = (err == mbtrc_pkg::ERR_NONE);

  // Output register: load whenever empty or being drained
  assign pop = head_valid && (!valid_r || !out_stall);

  always_comb begin
    valid_nxt = valid_r;
    if (pop)
      valid_nxt = 1'b1;
    else if (!out_stall)
      valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Decoded fields are cleared on any failed check
  always_ff @(posedge clk) begin
    if (pop) begin
      ok_r    <= ok;
      err_r   <= err;
      trans_r <= ok ? trans_id : '0;
      proto_r <= ok ? proto_id : '0;
      len_r   <= ok ? len_field : '0;
      unit_r  <= ok ? unit : '0;
      fc_r    <= ok ? fc : '0;
      addr_r  <= ok ? start_addr : '0;
      qty_r   <= (ok && (fc != mbtrc_pkg::FC_WRITE_SINGLE)) ? word10 : '0;
      wval_r  <= (ok && (fc == mbtrc_pkg::FC_WRITE_SINGLE)) ? word10 : '0;
    end
  end

  assign out_valid          = valid_r;
  assign out_ok             = ok_r;
  assign out_error_code     = err_r;
  assign out_txn_id         = trans_r;
  assign out_proto          = proto_r;
  assign out_length_field   = len_r;
  assign out_unit_id        = unit_r;
  assign out_func           = fc_r;
  assign out_start_address  = addr_r;
  assign out_quantity       = qty_r;
  assign out_write_value    = wval_r;

endmodule

`default_nettype wire

// ===== sv/modbus_tcp_request_checker.sv =====
// A finished request is registered in the queue, then in the result register.
// One byte per cycle unless the queue is full; front counts and captures, back checks.
// A two-entry request queue lets the front keep taking bytes while a result is stalled.
// Reset (synchronous, active low) clears the byte count, queue and result valid;
// captured header bytes are not reset.
`timescale 1ns / 1ps
`default_nettype none

module modbus_tcp_request_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_ok,
  output logic [3:0]       out_error_code,
  output logic [15:0]      out_txn_id,
  output logic [15:0]      out_proto,
  output logic [15:0]      out_length_field,
  output logic [7:0]       out_unit_id,
  output logic [7:0]       out_func,
  output logic [15:0]      out_start_address,
  output logic [15:0]      out_quantity,
  output logic [15:0]      out_write_value
);

  logic              q_full, q_push, q_pop, q_head_valid;
  mbtrc_pkg::frame_t q_push_frame, q_head_frame;

  mbtrc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_frame      (q_push_frame)
  );

  mbtrc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_frame (q_push_frame),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_frame (q_head_frame)
  );

  mbtrc_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head_valid         (q_head_valid),
    .head_frame         (q_head_frame),
    .pop                (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_ok             (out_ok),
    .out_error_code     (out_error_code),
    .out_txn_id         (out_txn_id),
    .out_proto          (out_proto),
    .out_length_field   (out_length_field),
    .out_unit_id        (out_unit_id),
    .out_func           (out_func),
    .out_start_address  (out_start_address),
    .out_quantity       (out_quantity),
    .out_write_value    (out_write_value)
  );

endmodule

`default_nettype wire

// ===== verif/tb_modbus_tcp_request_checker.sv =====
// Self-checking testbench for the Modbus TCP request checker: byte stream in, one verdict out.
`timescale 1ns / 1ps

module tb_modbus_tcp_request_checker;
  import mbtrc_pkg::*;

  localparam int unsigned COUNT_CEIL   = (1 << CNT_W) - 1;
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned RANDOM_BYTES = 500;

  // One decoded request as it should leave the block
  typedef struct {
    logic        ok;
    err_t        code;
    logic [15:0] tid;
    logic [15:0] pid;
    logic [15:0] len;
    logic [7:0]  unit;
    logic [7:0]  fc;
    logic [15:0] addr;
    logic [15:0] qty;
    logic [15:0] wval;
  } verdict_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_ok;
  logic [3:0]  out_error_code;
  logic [15:0] out_txn_id;
  logic [15:0] out_proto;
  logic [15:0] out_length_field;
  logic [7:0]  out_unit_id;
  logic [7:0]  out_func;
  logic [15:0] out_start_address;
  logic [15:0] out_quantity;
  logic [15:0] out_write_value;

  // Shadow of the block's capture state
  int unsigned frame_count = 0;
  logic [7:0]  frame_hdr [HDR_DEPTH];

  verdict_t    pending_verdicts[$];
  logic [7:0]  frame_buf[$];
  int unsigned mismatches = 0;
  int unsigned bytes_sent = 0;
  int unsigned quiet_cycles = 0;
  int unsigned stall_hold = 0;
  bit          idle_on = 1'b1;

  modbus_tcp_request_checker DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data_byte       (in_data_byte),
    .in_last_byte       (in_last_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_ok             (out_ok),
    .out_error_code     (out_error_code),
    .out_txn_id         (out_txn_id),
    .out_proto          (out_proto),
    .out_length_field   (out_length_field),
    .out_unit_id        (out_unit_id),
    .out_func           (out_func),
    .out_start_address  (out_start_address),
    .out_quantity       (out_quantity),
    .out_write_value    (out_write_value)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Gap length: mostly short, now and then long
  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 30);
    return $urandom_range(1, 3);
  endfunction

  // Word with extra weight on the extremes
  function automatic logic [15:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Big-endian word out of the captured header; positions past the end wrap around
  function automatic logic [15:0] hdr_word(input int unsigned pos);
    return {frame_hdr[pos % HDR_DEPTH], frame_hdr[(pos + 1) % HDR_DEPTH]};
  endfunction

  // Frame checks in priority order
  function automatic err_t check_request(input int unsigned size);
    int unsigned len;
    int unsigned qty;
    int unsigned bc;
    logic [7:0]  fc;
    if (size < MIN_SIZE) return ERR_SHORT;
    if (hdr_word(2) != 16'h0000) return ERR_PROTOCOL;
    len = hdr_word(4);
    if (MBAP_FIXED + len != size) return ERR_LENGTH;
    if (size < 8) return ERR_NO_FUNC;
    fc = frame_hdr[7];
    if (fc == FC_READ_HOLDING || fc == FC_READ_INPUT) begin
      if (size < READ_MIN) return ERR_PAYLOAD;
      if (hdr_word(10) == 16'h0000) return ERR_QUANTITY;
      if (len != PDU_LEN_FIXED) return ERR_PAYLOAD;
      return ERR_NONE;
    end
    if (fc == FC_WRITE_SINGLE) begin
      if (size < READ_MIN) return ERR_PAYLOAD;
      if (len != PDU_LEN_FIXED) return ERR_PAYLOAD;
      return ERR_NONE;
    end
    if (fc == FC_WRITE_MULTI) begin
      if (size < WMULTI_MIN) return ERR_PAYLOAD;
      qty = hdr_word(10);
      if (qty == 0) return ERR_QUANTITY;
      bc = frame_hdr[12];
      if (bc != qty * 2) return ERR_BYTE_CNT;
      if (size != WMULTI_MIN + bc) return ERR_PAYLOAD;
      return ERR_NONE;
    end
    return ERR_UNSUP;
  endfunction

  // Capture one accepted byte; on the last byte queue the expected verdict
  task automatic absorb_byte(input logic [7:0] data, input logic last);
    int unsigned size;
    verdict_t    v;
    if (frame_count < HDR_DEPTH) frame_hdr[frame_count] = data;
    size = (frame_count >= COUNT_CEIL) ? COUNT_CEIL : frame_count + 1;
    if (!last) begin
      frame_count = size;
      return;
    end
    frame_count = 0;
    v = '{ok: 1'b0, code: ERR_NONE, tid: '0, pid: '0, len: '0, unit: '0, fc: '0,
          addr: '0, qty: '0, wval: '0};
    v.code = check_request(size);
    if (v.code == ERR_NONE) begin
      v.ok   = 1'b1;
      v.tid  = hdr_word(0);
      v.pid  = hdr_word(2);
      v.len  = hdr_word(4);
      v.unit = frame_hdr[6];
      v.fc   = frame_hdr[7];
      v.addr = hdr_word(8);
      if (frame_hdr[7] == FC_WRITE_SINGLE) v.wval = hdr_word(10);
      else v.qty = hdr_word(10);
    end
    pending_verdicts.push_back(v);
  endtask

  function automatic void compare_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  task automatic check_verdict();
    verdict_t want;
    if (pending_verdicts.size() == 0) begin
      $display("%0t: result with no request pending, error code %h", $time, out_error_code);
      mismatches++;
      return;
    end
    want = pending_verdicts.pop_front();
    compare_field("ok", 16'(want.ok), 16'(out_ok));
    compare_field("error_code", 16'(want.code), 16'(out_error_code));
    compare_field("txn_id", want.tid, out_txn_id);
    compare_field("proto", want.pid, out_proto);
    compare_field("length_field", want.len, out_length_field);
    compare_field("unit_id", 16'(want.unit), 16'(out_unit_id));
    compare_field("func", 16'(want.fc), 16'(out_func));
    compare_field("start_address", want.addr, out_start_address);
    compare_field("quantity", want.qty, out_quantity);
    compare_field("write_value", want.wval, out_write_value);
  endtask

  // Both channels observed at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) absorb_byte(in_data_byte, in_last_byte);
      if (out_valid && !out_stall) check_verdict();
    end
  end

  // Result-side back-pressure
  initial begin
    forever begin
      @(negedge clk);
      if (stall_hold == 0) begin
        if (idle_on && $urandom_range(0, 3) == 0) begin
          out_stall  <= 1'b1;
          stall_hold = pick_gap() - 1;
        end else begin
          out_stall  <= 1'b0;
          stall_hold = $urandom_range(0, 7);
        end
      end else begin
        stall_hold--;
      end
    end
  end

  // Watchdog on cycles without any handshake
  initial begin
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Send one byte, with an optional gap before it; returns at the falling edge
  task automatic send_byte(input logic [7:0] data, input logic last);
    int unsigned gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= data;
    in_last_byte <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_frame();
    foreach (frame_buf[i]) send_byte(frame_buf[i], i == frame_buf.size() - 1);
  endtask

  // MBAP header with the length left blank, then the function code
  task automatic begin_frame(input logic [15:0] tid, input logic [7:0] unit,
                             input logic [7:0] fc);
    frame_buf = '{tid[15:8], tid[7:0], 8'h00, 8'h00, 8'h00, 8'h00, unit, fc};
  endtask

  task automatic put_word(input logic [15:0] w);
    frame_buf.push_back(w[15:8]);
    frame_buf.push_back(w[7:0]);
  endtask

  task automatic put_random_bytes(input int unsigned n);
    repeat (n) frame_buf.push_back(8'($urandom));
  endtask

  // Length field made to match the frame
  task automatic seal_frame();
    logic [15:0] len;
    len = 16'(frame_buf.size() - 6);
    frame_buf[4] = len[15:8];
    frame_buf[5] = len[7:0];
  endtask

  task automatic word_request(input logic [7:0] fc, input logic [15:0] tid,
                              input logic [7:0] unit, input logic [15:0] addr,
                              input logic [15:0] w);
    begin_frame(tid, unit, fc);
    put_word(addr);
    put_word(w);
    seal_frame();
  endtask

  task automatic multi_write(input logic [15:0] tid, input logic [15:0] addr,
                             input logic [15:0] qty, input logic [7:0] bc,
                             input int unsigned n);
    begin_frame(tid, 8'($urandom), FC_WRITE_MULTI);
    put_word(addr);
    put_word(qty);
    frame_buf.push_back(bc);
    put_random_bytes(n);
    seal_frame();
  endtask

  // Read requests at the field extremes, and a zero quantity
  task automatic test_reads();
    word_request(FC_READ_HOLDING, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF);
    send_frame();
    word_request(FC_READ_INPUT, 16'h0000, 8'h00, 16'h0000, 16'h0001);
    send_frame();
    word_request(FC_READ_HOLDING, 16'h1234, 8'h11, 16'h0100, 16'h0000);
    send_frame();
  endtask

  task automatic test_write_single();
    word_request(FC_WRITE_SINGLE, 16'hA5A5, 8'h01, 16'hFFFF, 16'h0000);
    send_frame();
    word_request(FC_WRITE_SINGLE, 16'h5A5A, 8'hFE, 16'h0000, 16'hFFFF);
    send_frame();
  endtask

  task automatic test_write_multi();
    multi_write(16'h0001, 16'h0010, 16'd1, 8'd2, 2);
    send_frame();
    multi_write(16'hFFFE, 16'hFFFF, 16'd127, 8'd254, 254);
    send_frame();
    // zero quantity, wrong byte count, one byte too many
    multi_write(16'h0002, 16'h0000, 16'd0, 8'd0, 0);
    send_frame();
    multi_write(16'h0003, 16'h0020, 16'd2, 8'd3, 3);
    send_frame();
    multi_write(16'h0004, 16'h0030, 16'd2, 8'd4, 5);
    send_frame();
  endtask

  task automatic test_header_errors();
    // short frames
    frame_buf = '{8'h5A};
    send_frame();
    begin_frame(16'h0BAD, 8'h01, FC_READ_HOLDING);
    void'(frame_buf.pop_back());
    send_frame();
    // nonzero protocol id, both bytes
    word_request(FC_READ_HOLDING, 16'h0101, 8'h01, 16'h0000, 16'h0001);
    frame_buf[3] = 8'h01;
    send_frame();
    word_request(FC_READ_INPUT, 16'h0102, 8'h01, 16'h0000, 16'h0001);
    frame_buf[2] = 8'hFF;
    send_frame();
    // length field off by one
    word_request(FC_WRITE_SINGLE, 16'h0103, 8'h01, 16'h0000, 16'h0001);
    frame_buf[5] = frame_buf[5] + 8'd1;
    send_frame();
    // unsupported function codes
    word_request(8'h00, 16'h0104, 8'h01, 16'h0000, 16'h0001);
    send_frame();
    word_request(8'hFF, 16'h0105, 8'h01, 16'h0000, 16'h0001);
    send_frame();
  endtask

  // Payload too short or too long for the function
  task automatic test_payload_errors();
    begin_frame(16'h0201, 8'h02, FC_READ_HOLDING);
    seal_frame();
    send_frame();
    begin_frame(16'h0202, 8'h02, FC_WRITE_MULTI);
    put_word(16'h0001);
    put_word(16'h0001);
    seal_frame();
    send_frame();
    begin_frame(16'h0203, 8'h02, FC_READ_INPUT);
    put_word(16'h0001);
    put_word(16'h0002);
    put_random_bytes(2);
    seal_frame();
    send_frame();
    begin_frame(16'h0204, 8'h02, FC_WRITE_SINGLE);
    put_word(16'h0001);
    put_word(16'h0002);
    put_random_bytes(1);
    seal_frame();
    send_frame();
  endtask

  // Mostly well-formed requests with random content, some damaged, some noise
  task automatic random_request();
    int unsigned kind;
    int unsigned qty;
    logic [7:0]  bc;
    int unsigned n;
    kind = $urandom_range(0, 6);
    case (kind)
      0, 1: word_request($urandom_range(0, 1) ? FC_READ_HOLDING : FC_READ_INPUT,
                         rand_word(), 8'($urandom), rand_word(), rand_word());
      2: word_request(FC_WRITE_SINGLE, rand_word(), 8'($urandom), rand_word(), rand_word());
      3, 4: begin
        qty = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 200) : $urandom_range(1, 6);
        bc  = 8'(qty * 2);
        if ($urandom_range(0, 7) == 0) bc = bc + 8'($urandom_range(1, 3));
        n = bc;
        if ($urandom_range(0, 7) == 0) n = n + $urandom_range(0, 2) - 1;
        if (n > 300) n = 0;
        multi_write(rand_word(), rand_word(), 16'(qty), bc, n);
      end
      5: begin
        begin_frame(rand_word(), 8'($urandom), 8'($urandom));
        put_random_bytes($urandom_range(0, 8));
        seal_frame();
      end
      default: begin
        frame_buf.delete();
        put_random_bytes($urandom_range(1, 20));
      end
    endcase
    // occasional damage to a well-formed request
    if (kind != 6) begin
      case ($urandom_range(0, 9))
        0: frame_buf[$urandom_range(2, 3)] = 8'($urandom_range(1, 255));
        1: frame_buf[$urandom_range(4, 5)] = 8'($urandom);
        2: repeat ($urandom_range(1, frame_buf.size() - 1)) void'(frame_buf.pop_back());
        3: put_random_bytes($urandom_range(1, 3));
        default: ;
      endcase
    end
    send_frame();
  endtask

  task automatic test_random();
    int unsigned first;
    first = bytes_sent;
    while (bytes_sent - first < RANDOM_BYTES) begin
      idle_on = ($urandom_range(0, 7) != 0);
      random_request();
    end
    idle_on = 1'b1;
  endtask

  // Test sequence
  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reads();
    test_write_single();
    test_write_multi();
    test_header_errors();
    test_payload_errors();
    test_random();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
